// ===== design/spt_pkg.sv =====
// Shared types and constants for the spectrum trace processor.
`timescale 1ns / 1ps
package spt_pkg;

	// number of frequency bins held in each store
	localparam int NumBins = 64;
	localparam int AddrW   = $clog2(NumBins);
	localparam int LvlW    = 13;
	localparam int HgtW    = 8;

	// -200 dBm in 1/16 dBm
	localparam logic signed [LvlW-1:0] Sentinel = -13'sd3200;

	// input word kinds (tuser)
	localparam logic [1:0] OpSample  = 2'd0;
	localparam logic [1:0] OpAdvance = 2'd1;
	localparam logic [1:0] OpEnter   = 2'd2;
	localparam logic [1:0] OpIgnore  = 2'd3;

	// display modes
	localparam logic [1:0] ModeSweep = 2'd0;
	localparam logic [1:0] ModeHold  = 2'd1;
	localparam logic [1:0] ModeAvg   = 2'd2;

	// colour classes
	localparam logic [1:0] ColGreen  = 2'd0;
	localparam logic [1:0] ColYellow = 2'd1;
	localparam logic [1:0] ColRed    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] RegWeight  = 3'd0;
	localparam logic [2:0] RegFloor   = 3'd1;
	localparam logic [2:0] RegCeiling = 3'd2;
	localparam logic [2:0] RegBarMax  = 3'd3;
	localparam logic [2:0] RegRed     = 3'd4;
	localparam logic [2:0] RegYellow  = 3'd5;
	localparam logic [2:0] RegBins    = 3'd6;

	// controller commands to the datapath
	typedef struct packed {
		logic       capture;
		logic       read;
		logic       update;
		logic       div_load;
		logic       div_step;
		logic       div_sel_hold;
		logic       latch_bar;
		logic       out_load;
		logic [2:0] div_bit;
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic is_sample;
		logic hold_mode;
	} status_t;

endpackage

// ===== design/spt_ram.sv =====
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps
module spt_ram #(
	parameter int Width = 13,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/spt_datapath.sv =====
// Datapath: configuration registers, trace stores, averaging and bar height divider.
`timescale 1ns / 1ps
module spt_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_addr,
	input  logic [8:0]            cfg_wdata,
	input  logic [1:0]            in_tuser,
	input  logic [23:0]           in_tdata,
	input  spt_pkg::cmd_t         cmd,
	output spt_pkg::status_t      status,
	output logic [63:0]           out_tdata,
	output logic                  out_tlast
);
	import spt_pkg::*;

	// configuration registers
	logic [8:0]        weight_q;
	logic signed [8:0] floor_q, ceil_q, red_q, yellow_q;
	logic [7:0]        barmax_q;
	logic [6:0]        bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 9'd51;
			floor_q  <= -9'sd135;
			ceil_q   <= -9'sd40;
			barmax_q <= 8'd38;
			red_q    <= -9'sd80;
			yellow_q <= -9'sd100;
			bins_q   <= 7'd53;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegWeight:  weight_q <= cfg_wdata;
				RegFloor:   floor_q  <= cfg_wdata;
				RegCeiling: ceil_q   <= cfg_wdata;
				RegBarMax:  barmax_q <= cfg_wdata[7:0];
				RegRed:     red_q    <= cfg_wdata;
				RegYellow:  yellow_q <= cfg_wdata;
				RegBins:    bins_q   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// captured input word
	logic [1:0]             op_q;
	logic [AddrW-1:0]       bin_q;
	logic signed [LvlW-1:0] smp_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_tuser;
			bin_q <= in_tdata[AddrW-1:0];
			smp_q <= in_tdata[18:6];
		end
	end

	// stores; entries with clear valid bits read as the sentinel
	logic [LvlW-1:0] last_rd, avg_rd, hold_rd;
	logic            last_we, avg_we, hold_we;
	logic signed [LvlW-1:0] shown_d, hold_new;

	spt_ram #(.Width(LvlW), .Depth(NumBins)) u_last (
		.clk(clk), .we(last_we), .waddr(bin_q), .wdata(smp_q),
		.re(cmd.capture), .raddr(in_tdata[AddrW-1:0]), .rdata(last_rd)
	);
	spt_ram #(.Width(LvlW), .Depth(NumBins)) u_avg (
		.clk(clk), .we(avg_we), .waddr(bin_q), .wdata(shown_d),
		.re(cmd.capture), .raddr(in_tdata[AddrW-1:0]), .rdata(avg_rd)
	);
	spt_ram #(.Width(LvlW), .Depth(NumBins)) u_hold (
		.clk(clk), .we(hold_we), .waddr(bin_q), .wdata(hold_new),
		.re(cmd.capture), .raddr(in_tdata[AddrW-1:0]), .rdata(hold_rd)
	);

	// last_vld: entry written; hold_vld: written since hold entry;
	// link: average entry still equals the last-sweep entry (seeded copy)
	logic [NumBins-1:0] last_vld_q, hold_vld_q, link_q;
	logic [1:0]         mode_q;
	logic [1:0]         mode_adv;

	assign mode_adv = (mode_q == ModeAvg) ? ModeSweep : mode_q + 2'd1;
	assign status.is_sample = (op_q == OpSample);
	assign status.hold_mode = (mode_q == ModeHold);

	// read stage: resolve old values, weighted difference
	logic signed [LvlW-1:0] last_old, avg_old, hold_old, seed;
	logic [8:0]             wc;
	logic signed [13:0]     diff;
	logic signed [LvlW-1:0] seed_q, hold_old_q;
	logic signed [23:0]     prod_q;

	always_comb begin
		last_old = last_vld_q[bin_q] ? $signed(last_rd) : Sentinel;
		avg_old  = link_q[bin_q] ? last_old : $signed(avg_rd);
		hold_old = hold_vld_q[bin_q] ? $signed(hold_rd) : Sentinel;
		seed     = (avg_old == Sentinel) ? smp_q : avg_old;
		wc       = (weight_q > 9'd256) ? 9'd256 : weight_q;
		diff     = $signed({smp_q[LvlW-1], smp_q}) - $signed({seed[LvlW-1], seed});
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			seed_q     <= seed;
			hold_old_q <= hold_old;
			prod_q     <= $signed({{10{diff[13]}}, diff}) * $signed({15'b0, wc});
		end
	end

	// update stage: shown level, peak, colour, store writes
	logic signed [24:0]     rnd;
	logic signed [16:0]     avg_sum;
	logic signed [LvlW-1:0] pk_base;
	logic signed [LvlW-1:0] red_lvl, yel_lvl;
	logic [1:0]             col_d;

	always_comb begin
		rnd      = $signed({prod_q[23], prod_q}) + 25'sd128;
		avg_sum  = $signed({{4{seed_q[LvlW-1]}}, seed_q}) + rnd[24:8];
		shown_d  = (mode_q == ModeAvg) ? avg_sum[LvlW-1:0] : smp_q;
		hold_new = (shown_d > hold_old_q) ? shown_d : hold_old_q;
		red_lvl  = {red_q, 4'b0};
		yel_lvl  = {yellow_q, 4'b0};
		if (shown_d >= red_lvl) begin
			col_d = ColRed;
		end else if (shown_d >= yel_lvl) begin
			col_d = ColYellow;
		end else begin
			col_d = ColGreen;
		end
		last_we = cmd.update && status.is_sample;
		avg_we  = last_we && (mode_q == ModeAvg);
		hold_we = last_we && status.hold_mode;
	end

	logic signed [LvlW-1:0] peak_q, shown_q, hold_q;
	logic [AddrW-1:0]       peak_bin_q;
	logic [1:0]             col_q;
	logic                   send_q;

	assign pk_base = (bin_q == '0) ? Sentinel : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ModeSweep;
			last_vld_q <= '0;
			hold_vld_q <= '0;
			link_q     <= '1;
			peak_q     <= Sentinel;
			peak_bin_q <= '0;
		end else if (cmd.update) begin
			unique case (op_q)
				OpSample: begin
					last_vld_q[bin_q] <= 1'b1;
					if (mode_q == ModeAvg) begin
						link_q[bin_q] <= 1'b0;
					end
					if (status.hold_mode) begin
						hold_vld_q[bin_q] <= 1'b1;
					end
					if (shown_d > pk_base) begin
						peak_q     <= shown_d;
						peak_bin_q <= bin_q;
					end else begin
						peak_q     <= pk_base;
						peak_bin_q <= (bin_q == '0) ? '0 : peak_bin_q;
					end
				end
				OpAdvance: begin
					mode_q <= mode_adv;
					if (mode_adv == ModeHold) begin
						hold_vld_q <= '0;
					end else if (mode_adv == ModeAvg) begin
						link_q <= '1;
					end
				end
				OpEnter: mode_q <= ModeSweep;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			shown_q <= shown_d;
			hold_q  <= hold_new;
			col_q   <= col_d;
			send_q  <= ({1'b0, bin_q} + 7'd1 == bins_q);
		end
	end

	// bar height: clamp, scale, then restoring divide one quotient bit a cycle
	logic signed [LvlW-1:0] lo, hi, lvl, lvl_c;
	logic [LvlW-1:0]        num_d, span;
	logic [20:0]            rem_q;
	logic [LvlW-1:0]        den_q;
	logic [HgtW-1:0]        quo_q, dval_q, bar_q, div_res;
	logic                   degen_q;
	logic [19:0]            dsh;

	always_comb begin
		lo    = {floor_q, 4'b0};
		hi    = {ceil_q, 4'b0};
		lvl   = cmd.div_sel_hold ? hold_q : shown_q;
		lvl_c = (lvl < lo) ? lo : ((lvl > hi) ? hi : lvl);
		num_d = LvlW'(lvl_c - lo);
		span  = LvlW'(hi - lo);
		dsh   = 20'({7'b0, den_q} << cmd.div_bit);
		div_res = degen_q ? dval_q : quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			degen_q <= (hi <= lo);
			dval_q  <= (lvl >= lo) ? barmax_q : '0;
			rem_q   <= {8'b0, num_d} * {13'b0, barmax_q};
			den_q   <= span;
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			if ({1'b0, dsh} <= rem_q) begin
				rem_q                <= rem_q - {1'b0, dsh};
				quo_q[cmd.div_bit]   <= 1'b1;
			end
		end
		if (cmd.latch_bar) begin
			bar_q <= div_res;
		end
	end

	// result word
	logic [63:0] out_d;
	logic        tlast_d;

	always_comb begin
		out_d          = '0;
		out_d[5:0]     = bin_q;
		out_d[38:37]   = mode_q;
		out_d[51:39]   = peak_q;
		out_d[57:52]   = peak_bin_q;
		tlast_d        = 1'b0;
		if (status.is_sample) begin
			out_d[18:6]  = shown_q;
			out_d[26:19] = status.hold_mode ? bar_q : div_res;
			out_d[28:27] = col_q;
			out_d[36:29] = status.hold_mode ? div_res : '0;
			tlast_d      = send_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_tdata <= out_d;
			out_tlast <= tlast_d;
		end
	end
endmodule

// ===== design/spt_ctrl.sv =====
// Controller: sequences read, update, divides and result hand-off.
`timescale 1ns / 1ps
module spt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  spt_pkg::status_t status,
	output spt_pkg::cmd_t    cmd
);
	import spt_pkg::*;

	typedef enum logic [7:0] {
		StIdle = 8'b0000_0001,
		StRead = 8'b0000_0010,
		StUpd  = 8'b0000_0100,
		StBld  = 8'b0000_1000,
		StBdiv = 8'b0001_0000,
		StHld  = 8'b0010_0000,
		StHdiv = 8'b0100_0000,
		StOut  = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] bit_q;
	logic       out_free;

	assign s_tready = (state_q == StIdle);
	assign out_free = !m_tvalid || m_tready;

	// next state and commands
	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.div_bit      = bit_q;
		cmd.div_sel_hold = (state_q == StHld);
		unique case (state_q)
			StIdle: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = StRead;
				end
			end
			StRead: begin
				cmd.read = 1'b1;
				state_d  = StUpd;
			end
			StUpd: begin
				cmd.update = 1'b1;
				state_d    = status.is_sample ? StBld : StOut;
			end
			StBld: begin
				cmd.div_load = 1'b1;
				state_d      = StBdiv;
			end
			StBdiv: begin
				cmd.div_step = 1'b1;
				if (bit_q == 3'd0) begin
					state_d = status.hold_mode ? StHld : StOut;
				end
			end
			StHld: begin
				cmd.latch_bar = 1'b1;
				cmd.div_load  = 1'b1;
				state_d       = StHdiv;
			end
			StHdiv: begin
				cmd.div_step = 1'b1;
				if (bit_q == 3'd0) begin
					state_d = StOut;
				end
			end
			StOut: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			bit_q    <= 3'd7;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			// quotient bit counter, most significant first
			if (cmd.div_load) begin
				bit_q <= 3'd7;
			end else if (cmd.div_step) begin
				bit_q <= bit_q - 3'd1;
			end
			// output word valid flag
			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end
endmodule

// ===== design/spectrum_trace_processor.sv =====
// Top level of the spectrum trace processor.
`timescale 1ns / 1ps
// Spectrum trace processor: per-bin levels in, display results out.
// Input stream: s_tuser carries the word kind (sample, advance mode, enter
// screen); s_tdata carries bin and level. Output stream gives one result word
// per input word; m_tlast marks the last bin of a sweep.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle; the user
// must write only while the block is idle, which the block does not enforce.
// Mode words go through the read, update and output states; a sample adds the
// bar divide, and a sample in hold mode also the hold divide. Each bar
// height is worked out by a restoring divider, run once for the bar and
// once more for the hold marker; one word is in flight at a time.
// s_tready is high only while the controller is idle. A finished result
// sits in the output register while the next word is taken and processed; if
// the receiver stalls, the block waits with its next result until it is taken.
// Reset: configuration registers return to defaults, the mode to sweep, and all stores read
// as -200 dBm at once through per-entry valid bits (no clearing pass).
module spectrum_trace_processor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // bin_index[5:0], rssi_sample[18:6]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// bin_echo[5:0], shown_level[18:6], bar_height[26:19], bar_color[28:27],
	// hold_height[36:29], current_mode[38:37], peak_level[51:39], peak_bin[57:52]
	output logic [63:0] m_tdata,
	output logic        m_tlast,  // sweep_end
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [8:0]  cfg_wdata
);
	import spt_pkg::*;

	cmd_t    cmd;
	status_t status;

	spt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.status(status), .cmd(cmd)
	);

	spt_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_tuser(s_tuser), .in_tdata(s_tdata),
		.cmd(cmd), .status(status),
		.out_tdata(m_tdata), .out_tlast(m_tlast)
	);
endmodule

// ===== design/spt_checker.sv =====
// Port-level checks of the spectrum trace processor, bound to the top level.
`timescale 1ns / 1ps
module spt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one word in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in flight");

	// colour class never takes the unused code
	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:27] != 2'b11)
		else $error("bad colour class");

	// hold marker only in hold mode
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38:37] != 2'd1 |-> m_tdata[36:29] == 8'd0)
		else $error("hold marker outside hold mode");
endmodule

bind spectrum_trace_processor spt_checker u_spt_checker (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata)
);
